/* hdl/circular_fifo_with_reverse_macros.svh */
// Assertion shorthands, clocked on i_clk and quiet while i_rst_n is low.
`ifndef CIRCULAR_FIFO_WITH_REVERSE_MACROS_SVH
`define CIRCULAR_FIFO_WITH_REVERSE_MACROS_SVH

// prop must hold at every clock edge
`define CFWR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// expr must never be true
`define CFWR_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`endif

/* hdl/cfwr_pkg.sv */
package cfwr_pkg;

    localparam int CNT_W   = 5;
    localparam int FIELD_W = 32;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

    // register index, taken from paddr[APB_AW-1:2]
    localparam logic [APB_AW-3:0] REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        KIND_PUSH    = 2'd0,
        KIND_POP     = 2'd1,
        KIND_CLEAR   = 2'd2,
        KIND_REVERSE = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP_RD,
        ST_SW_RHI,
        ST_SW_WLO,
        ST_SW_WHI
    } t_state;

    typedef struct packed {
        t_kind              kind;
        logic [FIELD_W-1:0] data_in;
    } t_item;

    typedef struct packed {
        logic [FIELD_W-1:0] popped_data;
        logic               pop_valid;
        logic               push_dropped;
        logic [CNT_W-1:0]   count;
        logic               full_res;
        logic               empty_res;
        logic [FIELD_W-1:0] front_data;
        logic [FIELD_W-1:0] rear_data;
    } t_result;

    typedef struct packed {
        logic             clr;      // capacity write this cycle
        logic [CNT_W-1:0] eff_new;  // capacity in use after that write
        logic [CNT_W-1:0] eff;      // capacity in use now
    } t_cfg_ctl;

    // zero counts as one, anything above the built depth saturates
    function automatic logic [CNT_W-1:0] cap_eff_f(logic [CNT_W-1:0] cap,
                                                   int unsigned depth);
        logic [CNT_W-1:0] eff;
        if (cap == '0) begin
            eff = CNT_W'(1);
        end else if (32'(cap) > depth) begin
            eff = CNT_W'(depth);
        end else begin
            eff = cap;
        end
        return eff;
    endfunction

endpackage

/* hdl/cfwr_ram.sv */
module cfwr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/cfwr_regs.sv */
module cfwr_regs #(
    parameter int DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cfwr_pkg::APB_AW-1:0]   paddr,
    input  logic [cfwr_pkg::APB_DW-1:0]   pwdata,
    output logic [cfwr_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output cfwr_pkg::t_cfg_ctl            o_cfg
);
    import cfwr_pkg::*;

    logic [CNT_W-1:0] r_cap;
    logic [CNT_W-1:0] r_cap_eff;
    logic [CNT_W-1:0] n_cap;
    logic             wr_cap;
    logic             sel_cap;

    assign sel_cap = (paddr[APB_AW-1:2] == REG_CAPACITY);
    assign wr_cap  = psel && penable && pwrite && sel_cap;
    assign n_cap   = pwdata[CNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= CAP_RESET;
            r_cap_eff <= cap_eff_f(CAP_RESET, DEPTH);
        end else if (wr_cap) begin
            r_cap     <= n_cap;
            r_cap_eff <= cap_eff_f(n_cap, DEPTH);
        end
    end

    assign pready        = 1'b1;
    assign prdata        = sel_cap ? APB_DW'(r_cap) : '0;
    assign o_cfg.clr     = wr_cap;
    assign o_cfg.eff_new = cap_eff_f(n_cap, DEPTH);
    assign o_cfg.eff     = r_cap_eff;

endmodule

/* hdl/circular_fifo_with_reverse.sv */
// Channel   | Handshake              | Payload           | Direction
// ----------+------------------------+-------------------+----------
// command   | start / busy           | i_item (t_item)   | in
// result    | o_valid, one cycle     | o_result          | out
// config    | APB psel/penable/...   | pwdata / prdata   | in/out
//
// Push, clear, pop on empty or of the last entry, and reverse of fewer than two entries
// finish in the accept cycle; a pop that leaves entries adds ST_POP_RD, the new front
// coming back from the RAM. Reverse of n entries runs floor(n/2) swaps of read hi, write
// lo, write hi; each low read rides on the accept cycle or on the previous high write.
// The result beat follows the last work cycle; busy is high while a pop or reverse is in
// flight. Reset is synchronous, active low, ring kept; the result side cannot stall.
`include "circular_fifo_with_reverse_macros.svh"

module circular_fifo_with_reverse #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command
    input  logic                          start,
    output logic                          busy,
    input  cfwr_pkg::t_item               i_item,
    // result
    output logic                          o_valid,
    output cfwr_pkg::t_result             o_result,
    // config
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cfwr_pkg::APB_AW-1:0]   paddr,
    input  logic [cfwr_pkg::APB_DW-1:0]   pwdata,
    output logic [cfwr_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import cfwr_pkg::*;

    localparam int PW = $clog2(DEPTH);
    // room for pointer + offset before the wrap subtract
    localparam int LW = ((PW > CNT_W) ? PW : CNT_W) + 1;
    localparam logic [CNT_W-1:0] CAP_EFF_RST = cap_eff_f(CAP_RESET, DEPTH);

    t_cfg_ctl cfg;

    // ring RAM port
    logic                  mem_we;
    logic [PW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [PW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    // queue state; front/rear copies mirror ring[head] and ring[tail]
    t_state                r_state, n_state;
    logic [PW-1:0]         r_head, n_head;
    logic [PW-1:0]         r_tail, n_tail;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [DATA_WIDTH-1:0] r_front, n_front;
    logic [DATA_WIDTH-1:0] r_rear, n_rear;
    // reverse sequencer
    logic [PW-1:0]         r_lo, n_lo;
    logic [PW-1:0]         r_hi, n_hi;
    logic [CNT_W-2:0]      r_swaps, n_swaps;
    logic [DATA_WIDTH-1:0] r_tmp, n_tmp;
    // result beat
    logic                  r_valid, n_valid;
    t_result               r_res, n_res;

    logic [DATA_WIDTH-1:0] din;
    logic                  accept;

    function automatic logic [PW-1:0] wrap_add(logic [PW-1:0] p, logic [CNT_W-1:0] n,
                                               logic [CNT_W-1:0] cap);
        logic [LW-1:0] s;
        s = LW'(p) + LW'(n);
        if (s >= LW'(cap)) begin
            s = s - LW'(cap);
        end
        return PW'(s);
    endfunction

    function automatic logic [PW-1:0] wrap_dec(logic [PW-1:0] p, logic [CNT_W-1:0] cap);
        return (p == '0) ? PW'(cap - CNT_W'(1)) : p - PW'(1);
    endfunction

    // zeroes the fields that do not apply
    function automatic t_result mk_res(logic [DATA_WIDTH-1:0] popped, logic pv, logic drop,
                                       logic [CNT_W-1:0] cnt, logic [DATA_WIDTH-1:0] front,
                                       logic [DATA_WIDTH-1:0] rear, logic [CNT_W-1:0] cap);
        t_result res;
        res.popped_data  = pv ? FIELD_W'(popped) : '0;
        res.pop_valid    = pv;
        res.push_dropped = drop;
        res.count        = cnt;
        res.full_res     = (cnt == cap);
        res.empty_res    = (cnt == '0);
        res.front_data   = (cnt != '0) ? FIELD_W'(front) : '0;
        res.rear_data    = (cnt != '0) ? FIELD_W'(rear) : '0;
        return res;
    endfunction

    cfwr_regs #(
        .DEPTH (DEPTH)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cfwr_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign din    = DATA_WIDTH'(i_item.data_in);

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_front   = r_front;
        n_rear    = r_rear;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_swaps   = r_swaps;
        n_tmp     = r_tmp;
        n_valid   = 1'b0;
        n_res     = r_res;
        mem_we    = 1'b0;
        mem_waddr = r_lo;
        mem_wdata = mem_rdata;
        mem_raddr = r_lo;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_valid = 1'b1;
                    case (i_item.kind)
                        KIND_PUSH: begin
                            if (r_count >= cfg.eff) begin
                                n_res = mk_res('0, 1'b0, 1'b1, r_count, r_front, r_rear,
                                               cfg.eff);
                            end else begin
                                n_tail    = wrap_add(r_tail, CNT_W'(1), cfg.eff);
                                n_count   = r_count + CNT_W'(1);
                                n_rear    = din;
                                mem_we    = 1'b1;
                                mem_waddr = n_tail;
                                mem_wdata = din;
                                if (r_count == '0) begin
                                    n_front = din;
                                end
                                n_res = mk_res('0, 1'b0, 1'b0, n_count, n_front, n_rear,
                                               cfg.eff);
                            end
                        end
                        KIND_POP: begin
                            if (r_count == '0) begin
                                n_res = mk_res('0, 1'b0, 1'b0, r_count, r_front, r_rear,
                                               cfg.eff);
                            end else begin
                                n_head    = wrap_add(r_head, CNT_W'(1), cfg.eff);
                                n_count   = r_count - CNT_W'(1);
                                n_tmp     = r_front;
                                mem_raddr = n_head;
                                if (n_count == '0) begin
                                    n_res = mk_res(r_front, 1'b1, 1'b0, n_count, r_front,
                                                   r_rear, cfg.eff);
                                end else begin
                                    // new front comes back next cycle
                                    n_valid = 1'b0;
                                    n_state = ST_POP_RD;
                                end
                            end
                        end
                        KIND_CLEAR: begin
                            n_head  = '0;
                            n_tail  = PW'(cfg.eff - CNT_W'(1));
                            n_count = '0;
                            n_res   = mk_res('0, 1'b0, 1'b0, n_count, r_front, r_rear,
                                             cfg.eff);
                        end
                        KIND_REVERSE: begin
                            if (r_count < CNT_W'(2)) begin
                                n_res = mk_res('0, 1'b0, 1'b0, r_count, r_front, r_rear,
                                               cfg.eff);
                            end else begin
                                n_valid   = 1'b0;
                                n_lo      = r_head;
                                n_hi      = wrap_add(r_head, r_count - CNT_W'(1), cfg.eff);
                                n_swaps   = r_count[CNT_W-1:1];
                                mem_raddr = r_head;
                                n_state   = ST_SW_RHI;
                            end
                        end
                        default: begin
                            n_valid = 1'b0;
                        end
                    endcase
                end
            end
            ST_POP_RD: begin
                n_front = mem_rdata;
                n_valid = 1'b1;
                n_res   = mk_res(r_tmp, 1'b1, 1'b0, r_count, mem_rdata, r_rear, cfg.eff);
                n_state = ST_IDLE;
            end
            ST_SW_RHI: begin
                // low entry arrives, fetch the high one
                n_tmp     = mem_rdata;
                mem_raddr = r_hi;
                n_state   = ST_SW_WLO;
            end
            ST_SW_WLO: begin
                mem_we    = 1'b1;
                mem_waddr = r_lo;
                mem_wdata = mem_rdata;
                n_state   = ST_SW_WHI;
            end
            ST_SW_WHI: begin
                mem_we    = 1'b1;
                mem_waddr = r_hi;
                mem_wdata = r_tmp;
                n_swaps   = r_swaps - (CNT_W-1)'(1);
                if (r_swaps == (CNT_W-1)'(1)) begin
                    // ends traded places
                    n_front = r_rear;
                    n_rear  = r_front;
                    n_valid = 1'b1;
                    n_res   = mk_res('0, 1'b0, 1'b0, r_count, r_rear, r_front, cfg.eff);
                    n_state = ST_IDLE;
                end else begin
                    // next pair never touches the entry written now
                    n_lo      = wrap_add(r_lo, CNT_W'(1), cfg.eff);
                    n_hi      = wrap_dec(r_hi, cfg.eff);
                    mem_raddr = n_lo;
                    n_state   = ST_SW_RHI;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // capacity write empties the queue; the user must write it only while idle, the block does not enforce this
        if (cfg.clr) begin
            n_head  = '0;
            n_tail  = PW'(cfg.eff_new - CNT_W'(1));
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_tail  <= PW'(CAP_EFF_RST - CNT_W'(1));
            r_count <= '0;
            r_swaps <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_swaps <= n_swaps;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front <= n_front;
        r_rear  <= n_rear;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_tmp   <= n_tmp;
        r_res   <= n_res;
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

    `CFWR_ASSERT(a_count_in_cap, r_count <= cfg.eff, "entry count above capacity in use")
    `CFWR_ASSERT(a_push_beat, accept && (i_item.kind == KIND_PUSH) |=> o_valid, "no push beat")
    `CFWR_NEVER(a_swap_underrun, (r_state == ST_SW_WHI) && (r_swaps == '0), "swap with none left")

endmodule
